>>> rtl/jse_pkg.sv
// ----------------------------------------------------------------------------
// jse_pkg
// shared types, constants and helpers of the json string escaper
// ----------------------------------------------------------------------------
package jse_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] QUOTE   = 8'h22;
    localparam logic [7:0] BSLASH  = 8'h5C;
    localparam logic [7:0] CH_U    = 8'h75;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] REPL_B0 = 8'hEF;
    localparam logic [7:0] REPL_B1 = 8'hBF;
    localparam logic [7:0] REPL_B2 = 8'hBD;

    localparam logic [3:0] MAX_RESULTS = 4'd15;

    // kind of the trailing part of a job
    localparam logic [2:0] TAIL_NONE  = 3'd0;
    localparam logic [2:0] TAIL_CLOSE = 3'd1;
    localparam logic [2:0] TAIL_SEQ   = 3'd2;
    localparam logic [2:0] TAIL_CHAR  = 3'd3;
    localparam logic [2:0] TAIL_ESC   = 3'd4;
    localparam logic [2:0] TAIL_UESC  = 3'd5;
    localparam logic [2:0] TAIL_REPL  = 3'd6;

    typedef struct packed {
        logic        open_quote;
        logic [1:0]  n_repl;
        logic [2:0]  tail;
        logic [2:0]  tail_len;
        logic [3:0]  total;
        logic [31:0] bytes;
    } jse_job_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] r;
        if (n < 4'd10)
        begin
            r = 8'h30 + {4'h0, n};
        end
        else
        begin
            r = 8'h57 + {4'h0, n};
        end
        return r;
    endfunction

    function automatic logic [7:0] repl_byte(input logic [1:0] k);
        logic [7:0] r;
        unique case (k)
            2'd0:    r = REPL_B0;
            2'd1:    r = REPL_B1;
            default: r = REPL_B2;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/jse_front.sv
// ----------------------------------------------------------------------------
// jse_front
// accepts words, tracks utf-8 sequences and turns each word into a job
// ----------------------------------------------------------------------------
module jse_front
    import jse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic       command,
    input  logic [7:0] data_byte,
    output jse_job_t   job,
    output logic       push
);

    logic       open_reg, open_next;
    logic [7:0] lead_reg, lead_next;
    logic [7:0] c0_reg, c0_next;
    logic [7:0] c1_reg, c1_next;
    logic [1:0] held_reg, held_next;
    logic [2:0] need_reg, need_next;

    logic       cont;
    logic       second_ok;
    logic       fresh;
    logic [7:0] esc;
    logic [4:0] tot5;

    assign cont = (data_byte[7:6] == 2'b10);
    assign second_ok = !((lead_reg == 8'hE0 && data_byte < 8'hA0) ||
                         (lead_reg == 8'hED && data_byte >= 8'hA0) ||
                         (lead_reg == 8'hF0 && data_byte < 8'h90) ||
                         (lead_reg == 8'hF4 && data_byte >= 8'h90));

    always_comb
    begin
        unique case (data_byte)
            8'h22:   esc = 8'h22;
            8'h5C:   esc = 8'h5C;
            8'h08:   esc = 8'h62;
            8'h0C:   esc = 8'h66;
            8'h0A:   esc = 8'h6E;
            8'h0D:   esc = 8'h72;
            8'h09:   esc = 8'h74;
            default: esc = 8'h00;
        endcase
    end

    always_comb
    begin
        open_next = 1'b1;
        lead_next = lead_reg;
        c0_next   = c0_reg;
        c1_next   = c1_reg;
        held_next = held_reg;
        need_next = need_reg;
        fresh     = 1'b0;

        job.open_quote = !open_reg;
        job.n_repl     = 2'd0;
        job.tail       = TAIL_NONE;
        job.tail_len   = 3'd0;
        job.bytes      = 32'h0;

        if (command)
        begin
            job.n_repl   = held_reg;
            held_next    = 2'd0;
            need_next    = 3'd0;
            job.tail     = TAIL_CLOSE;
            job.tail_len = 3'd1;
            open_next    = 1'b0;
        end
        else
        begin
            fresh = 1'b1;
            if (held_reg != 2'd0)
            begin
                if (cont && (held_reg != 2'd1 || second_ok))
                begin
                    fresh = 1'b0;
                    if ({1'b0, held_reg} + 3'd1 >= need_reg)
                    begin
                        job.tail     = TAIL_SEQ;
                        job.tail_len = {1'b0, held_reg} + 3'd1;
                        unique case (held_reg)
                            2'd1:    job.bytes = {16'h0, data_byte, lead_reg};
                            2'd2:    job.bytes = {8'h0, data_byte, c0_reg, lead_reg};
                            default: job.bytes = {data_byte, c1_reg, c0_reg, lead_reg};
                        endcase
                        held_next = 2'd0;
                        need_next = 3'd0;
                    end
                    else
                    begin
                        if (held_reg == 2'd1)
                        begin
                            c0_next = data_byte;
                        end
                        else
                        begin
                            c1_next = data_byte;
                        end
                        held_next = held_reg + 2'd1;
                    end
                end
                else
                begin
                    job.n_repl = held_reg;
                    held_next  = 2'd0;
                    need_next  = 3'd0;
                end
            end

            if (fresh)
            begin
                job.bytes = {24'h0, data_byte};
                priority if (data_byte < 8'h80)
                begin
                    if (esc != 8'h00)
                    begin
                        job.tail     = TAIL_ESC;
                        job.tail_len = 3'd2;
                        job.bytes    = {24'h0, esc};
                    end
                    else if (data_byte < 8'h20)
                    begin
                        job.tail     = TAIL_UESC;
                        job.tail_len = 3'd6;
                    end
                    else
                    begin
                        job.tail     = TAIL_CHAR;
                        job.tail_len = 3'd1;
                    end
                end
                else if (data_byte >= 8'hC2 && data_byte <= 8'hDF)
                begin
                    need_next = 3'd2;
                    lead_next = data_byte;
                    held_next = 2'd1;
                end
                else if (data_byte >= 8'hE0 && data_byte <= 8'hEF)
                begin
                    need_next = 3'd3;
                    lead_next = data_byte;
                    held_next = 2'd1;
                end
                else if (data_byte >= 8'hF0 && data_byte <= 8'hF4)
                begin
                    need_next = 3'd4;
                    lead_next = data_byte;
                    held_next = 2'd1;
                end
                else
                begin
                    job.tail     = TAIL_REPL;
                    job.tail_len = 3'd3;
                end
            end
        end

        tot5 = {4'h0, job.open_quote} + ({3'h0, job.n_repl} * 5'd3) + {2'h0, job.tail_len};
        job.total = (tot5 > {1'b0, MAX_RESULTS}) ? MAX_RESULTS : tot5[3:0];
    end

    assign push = accept && (job.total != 4'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            lead_reg <= 8'h0;
            c0_reg   <= 8'h0;
            c1_reg   <= 8'h0;
            held_reg <= 2'd0;
            need_reg <= 3'd0;
        end
        else if (accept)
        begin
            open_reg <= open_next;
            lead_reg <= lead_next;
            c0_reg   <= c0_next;
            c1_reg   <= c1_next;
            held_reg <= held_next;
            need_reg <= need_next;
        end
    end

endmodule

>>> rtl/jse_queue.sv
// ----------------------------------------------------------------------------
// jse_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module jse_queue
    import jse_pkg::*;
#(
    parameter int Depth = QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  jse_job_t push_job,
    input  logic     pop,
    output jse_job_t head_job,
    output logic     head_valid,
    output logic     full
);

    localparam int AW = $clog2(Depth);
    localparam int CW = $clog2(Depth + 1);

    jse_job_t        mem [Depth];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full       = (count_reg == CW'(Depth));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/jse_back.sv
// ----------------------------------------------------------------------------
// jse_back
// expands the head job into output words, one per cycle while out_ready does not stall the output
// ----------------------------------------------------------------------------
module jse_back
    import jse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  jse_job_t   job,
    input  logic       head_valid,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last_of_run,
    output logic       string_closed
);

    logic [3:0] pos_reg, pos_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       closed_reg;

    logic       fire;
    logic       is_last;
    logic [3:0] q;
    logic [3:0] rep_len;
    logic [3:0] t4;
    logic [2:0] t;
    logic       in_quote;
    logic       in_rep;
    logic [1:0] rep_idx;
    logic [7:0] cur_byte;
    logic       cur_closed;

    assign fire    = head_valid && (!valid_reg || out_ready);
    assign is_last = (pos_reg == job.total - 4'd1);
    assign pop     = fire && is_last;

    assign q        = pos_reg - {3'h0, job.open_quote};
    assign rep_len  = {1'b0, job.n_repl, 1'b0} + {2'h0, job.n_repl};
    assign t4       = q - rep_len;
    assign t        = t4[2:0];
    assign in_quote = job.open_quote && (pos_reg == 4'd0);
    assign in_rep   = !in_quote && (q < rep_len);

    always_comb
    begin
        unique case (q)
            4'd0, 4'd3, 4'd6: rep_idx = 2'd0;
            4'd1, 4'd4, 4'd7: rep_idx = 2'd1;
            default:          rep_idx = 2'd2;
        endcase
    end

    always_comb
    begin
        cur_closed = 1'b0;
        if (in_quote)
        begin
            cur_byte = QUOTE;
        end
        else if (in_rep)
        begin
            cur_byte = repl_byte(rep_idx);
        end
        else
        begin
            unique case (job.tail)
                TAIL_CLOSE:
                begin
                    cur_byte   = QUOTE;
                    cur_closed = 1'b1;
                end
                TAIL_SEQ:
                begin
                    cur_byte = job.bytes[{t[1:0], 3'b000} +: 8];
                end
                TAIL_ESC:
                begin
                    cur_byte = (t == 3'd0) ? BSLASH : job.bytes[7:0];
                end
                TAIL_UESC:
                begin
                    unique case (t)
                        3'd0:       cur_byte = BSLASH;
                        3'd1:       cur_byte = CH_U;
                        3'd2, 3'd3: cur_byte = CH_ZERO;
                        3'd4:       cur_byte = hex_digit(job.bytes[7:4]);
                        default:    cur_byte = hex_digit(job.bytes[3:0]);
                    endcase
                end
                TAIL_REPL:
                begin
                    cur_byte = repl_byte(t[1:0]);
                end
                default:
                begin
                    cur_byte = job.bytes[7:0];
                end
            endcase
        end
    end

    always_comb
    begin
        pos_next   = pos_reg;
        valid_next = valid_reg;
        if (fire)
        begin
            pos_next   = is_last ? 4'd0 : pos_reg + 4'd1;
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            byte_reg   <= cur_byte;
            last_reg   <= is_last;
            closed_reg <= cur_closed;
        end
    end

    assign out_valid     = valid_reg;
    assign out_byte      = byte_reg;
    assign last_of_run   = last_reg;
    assign string_closed = closed_reg;

endmodule

>>> rtl/json_string_escaper_utf8.sv
// path: accepted word -> job queue -> back end output register; throughput: one
//   output word per cycle unless out_ready stalls; a word that expands into k
//   output words holds the back end until all k are out, the front accepts words
//   until the job queue is full; words that produce nothing use the front only
// reset: rst_n clears the string and utf-8 state, empties the queue and
//   drops any pending output word
// ----------------------------------------------------------------------------
// json_string_escaper_utf8
// quoted json string escaper with utf-8 checking, front, queue and back end
// ----------------------------------------------------------------------------
module json_string_escaper_utf8
    import jse_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       command,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last_of_run,
    output logic       string_closed
);

    jse_job_t new_job;
    jse_job_t head_job;
    logic     push;
    logic     pop;
    logic     head_valid;
    logic     full;

    assign in_ready = !full;

    jse_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_valid && in_ready),
        .command   (command),
        .data_byte (data_byte),
        .job       (new_job),
        .push      (push)
    );

    jse_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (new_job),
        .pop        (pop),
        .head_job   (head_job),
        .head_valid (head_valid),
        .full       (full)
    );

    jse_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job           (head_job),
        .head_valid    (head_valid),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .last_of_run   (last_of_run),
        .string_closed (string_closed)
    );

endmodule

>>> rtl/jse_checker.sv
// ----------------------------------------------------------------------------
// jse_checker
// port-level checks of the json string escaper
// ----------------------------------------------------------------------------
module jse_checker
    import jse_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       command,
    input logic [7:0] data_byte,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       last_of_run,
    input logic       string_closed
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(command) && $stable(data_byte))
        else $error("input word changed while waiting");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
        $stable(last_of_run) && $stable(string_closed))
        else $error("output word changed while stalled");

    a_close_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_closed |-> out_byte == QUOTE && last_of_run)
        else $error("closing word is not a final quote");

    a_no_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_byte >= 8'h20)
        else $error("raw control byte on output");

endmodule

bind json_string_escaper_utf8 jse_checker u_jse_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .data_byte     (data_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .last_of_run   (last_of_run),
    .string_closed (string_closed)
);
